>>> hdl/bls_pkg.sv
// Shared types and constants for the Bresenham line stepper.
// No dependencies; imported by bls_line_setup and bresenham_line_stepper_core.
`default_nettype none

package bls_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEC_EXTRA_BITS = 4;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_STEP = 1'b1
    } t_func;

    typedef struct packed {
        logic x_dir_neg;
        logic y_dir_neg;
        logic steep;
    } t_line_flags;

endpackage

`default_nettype wire

>>> hdl/bls_line_setup.sv
// Line setup: absolute deltas, step directions, major axis, initial decision.
// Combinational only. Depends on bls_pkg.
`default_nettype none

module bls_line_setup #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    parameter int DEC_W      = bls_pkg::COORD_BITS_DEF + bls_pkg::DEC_EXTRA_BITS
) (
    input  wire logic [COORD_BITS-1:0] i_x_start,
    input  wire logic [COORD_BITS-1:0] i_y_start,
    input  wire logic [COORD_BITS-1:0] i_x_end,
    input  wire logic [COORD_BITS-1:0] i_y_end,
    output logic      [COORD_BITS-1:0] o_delta_x,
    output logic      [COORD_BITS-1:0] o_delta_y,
    output bls_pkg::t_line_flags       o_flags,
    output logic      [DEC_W-1:0]      o_dec_init,
    output logic      [COORD_BITS-1:0] o_steps_init
);
    import bls_pkg::*;

    logic [COORD_BITS:0]   w_dx;
    logic [COORD_BITS:0]   w_dy;
    logic [COORD_BITS:0]   w_dx_mag;
    logic [COORD_BITS:0]   w_dy_mag;
    logic                  w_steep;
    logic [COORD_BITS-1:0] w_major;
    logic [COORD_BITS-1:0] w_minor;

    // sign-extended differences, one bit wider than a coordinate
    assign w_dx = {i_x_end[COORD_BITS-1], i_x_end} - {i_x_start[COORD_BITS-1], i_x_start};
    assign w_dy = {i_y_end[COORD_BITS-1], i_y_end} - {i_y_start[COORD_BITS-1], i_y_start};

    assign w_dx_mag = w_dx[COORD_BITS] ? (~w_dx + 1'b1) : w_dx;
    assign w_dy_mag = w_dy[COORD_BITS] ? (~w_dy + 1'b1) : w_dy;

    assign o_delta_x = w_dx_mag[COORD_BITS-1:0];
    assign o_delta_y = w_dy_mag[COORD_BITS-1:0];

    // ties go to x as the major axis
    assign w_steep = o_delta_x < o_delta_y;
    assign w_major = w_steep ? o_delta_y : o_delta_x;
    assign w_minor = w_steep ? o_delta_x : o_delta_y;

    assign o_flags.x_dir_neg = w_dx[COORD_BITS];
    assign o_flags.y_dir_neg = w_dy[COORD_BITS];
    assign o_flags.steep     = w_steep;

    // 2*minor - major
    assign o_dec_init = {{(DEC_W-COORD_BITS-1){1'b0}}, w_minor, 1'b0}
                      - {{(DEC_W-COORD_BITS){1'b0}}, w_major};

    assign o_steps_init = w_major;

endmodule

`default_nettype wire

>>> hdl/bresenham_line_stepper_core.sv
// Top level of the Bresenham line stepper: stream ports, line state, output register.
// Depends on bls_pkg and bls_line_setup.
`default_nettype none

// The core takes one item per clock unless stalled and returns exactly one point
// per item, registered in the cycle after the transfer. A load (tuser = 0) latches
// both endpoints and returns the start point; each step (tuser = 1) returns the
// next pixel of the line, with tlast on the end point. A step with no line active
// returns an all-zero item with the valid flag (output tuser) low. The line state
// is updated on each transfer, which keeps the rate of one item per clock; the
// input is ready whenever the output register is empty or being drained.
module bresenham_line_stepper_core #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // x_start, y_start, x_end, y_end (lowest bits first), zero padded
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // func
    input  wire logic [0:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // point_x, point_y (lowest bits first), zero padded
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,
    // point_valid
    output logic      [0:0]            o_m_axis_tuser,
    // last_point
    output logic                       o_m_axis_tlast
);
    import bls_pkg::*;

    localparam int DEC_W = COORD_BITS + DEC_EXTRA_BITS;

    logic                  w_accept;
    logic [COORD_BITS-1:0] w_x_start;
    logic [COORD_BITS-1:0] w_y_start;
    logic [COORD_BITS-1:0] w_x_end;
    logic [COORD_BITS-1:0] w_y_end;

    logic [COORD_BITS-1:0] w_set_dx;
    logic [COORD_BITS-1:0] w_set_dy;
    t_line_flags           w_set_flags;
    logic [DEC_W-1:0]      w_set_dec;
    logic [COORD_BITS-1:0] w_set_steps;

    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [DEC_W-1:0]      r_dec, n_dec;
    logic [COORD_BITS-1:0] r_delta_x, n_delta_x;
    logic [COORD_BITS-1:0] r_delta_y, n_delta_y;
    t_line_flags           r_flags, n_flags;
    logic [COORD_BITS-1:0] r_steps, n_steps;
    logic                  r_active, n_active;

    logic                  r_m_valid;
    logic [COORD_BITS-1:0] r_pt_x, n_pt_x;
    logic [COORD_BITS-1:0] r_pt_y, n_pt_y;
    logic                  r_pt_valid, n_pt_valid;
    logic                  r_pt_last, n_pt_last;

    logic [COORD_BITS-1:0] w_major;
    logic [COORD_BITS-1:0] w_minor;
    logic                  w_dec_pos;
    logic                  w_x_move;
    logic                  w_y_move;
    logic [COORD_BITS-1:0] w_step_x;
    logic [COORD_BITS-1:0] w_step_y;
    logic [DEC_W-1:0]      w_step_dec;
    logic [COORD_BITS-1:0] w_step_steps;
    logic                  w_step_last;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_x_start = i_s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    assign w_y_start = i_s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    assign w_x_end   = i_s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    assign w_y_end   = i_s_axis_tdata[3*COORD_BITS +: COORD_BITS];

    bls_line_setup #(
        .COORD_BITS (COORD_BITS),
        .DEC_W      (DEC_W)
    ) u_setup (
        .i_x_start    (w_x_start),
        .i_y_start    (w_y_start),
        .i_x_end      (w_x_end),
        .i_y_end      (w_y_end),
        .o_delta_x    (w_set_dx),
        .o_delta_y    (w_set_dy),
        .o_flags      (w_set_flags),
        .o_dec_init   (w_set_dec),
        .o_steps_init (w_set_steps)
    );

    // one step along the active line
    assign w_major   = r_flags.steep ? r_delta_y : r_delta_x;
    assign w_minor   = r_flags.steep ? r_delta_x : r_delta_y;
    assign w_dec_pos = !r_dec[DEC_W-1] && (r_dec != '0);
    assign w_x_move  = !r_flags.steep || w_dec_pos;
    assign w_y_move  = r_flags.steep || w_dec_pos;

    assign w_step_x = w_x_move ? (r_flags.x_dir_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1)
                               : r_cur_x;
    assign w_step_y = w_y_move ? (r_flags.y_dir_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1)
                               : r_cur_y;

    assign w_step_dec = r_dec
                      + {{(DEC_W-COORD_BITS-1){1'b0}}, w_minor, 1'b0}
                      - (w_dec_pos ? {{(DEC_W-COORD_BITS-1){1'b0}}, w_major, 1'b0}
                                   : {DEC_W{1'b0}});

    assign w_step_steps = r_steps - 1'b1;
    assign w_step_last  = (w_step_steps == '0);

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_dec      = r_dec;
        n_delta_x  = r_delta_x;
        n_delta_y  = r_delta_y;
        n_flags    = r_flags;
        n_steps    = r_steps;
        n_active   = r_active;
        n_pt_x     = '0;
        n_pt_y     = '0;
        n_pt_valid = 1'b0;
        n_pt_last  = 1'b0;
        unique case (t_func'(i_s_axis_tuser[0]))
            FUNC_LOAD: begin
                n_cur_x    = w_x_start;
                n_cur_y    = w_y_start;
                n_dec      = w_set_dec;
                n_delta_x  = w_set_dx;
                n_delta_y  = w_set_dy;
                n_flags    = w_set_flags;
                n_steps    = w_set_steps;
                n_active   = (w_set_steps != '0);
                n_pt_x     = w_x_start;
                n_pt_y     = w_y_start;
                n_pt_valid = 1'b1;
                n_pt_last  = (w_set_steps == '0);
            end
            FUNC_STEP: begin
                if (r_active) begin
                    n_cur_x    = w_step_x;
                    n_cur_y    = w_step_y;
                    n_dec      = w_step_dec;
                    n_steps    = w_step_steps;
                    n_active   = !w_step_last;
                    n_pt_x     = w_step_x;
                    n_pt_y     = w_step_y;
                    n_pt_valid = 1'b1;
                    n_pt_last  = w_step_last;
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_steps  <= '0;
        end else if (w_accept) begin
            r_active <= n_active;
            r_steps  <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur_x   <= n_cur_x;
            r_cur_y   <= n_cur_y;
            r_dec     <= n_dec;
            r_delta_x <= n_delta_x;
            r_delta_y <= n_delta_y;
            r_flags   <= n_flags;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pt_x     <= n_pt_x;
            r_pt_y     <= n_pt_y;
            r_pt_valid <= n_pt_valid;
            r_pt_last  <= n_pt_last;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_pt_y, r_pt_x});
    assign o_m_axis_tuser  = r_pt_valid;
    assign o_m_axis_tlast  = r_pt_last;

`ifndef SYNTHESIS
    a_active_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_steps != '0))
        else $error("line active with no steps left");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_pt_valid && r_pt_last) |-> !r_active)
        else $error("end point shown while line still active");

    a_invalid_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_pt_valid) |-> (!r_pt_last && r_pt_x == '0 && r_pt_y == '0))
        else $error("idle step result carries a point");
`endif

endmodule

`default_nettype wire

>>> dv/tb_bresenham_line_stepper_core.sv
// Self-checking testbench for bresenham_line_stepper_core: directed and random
// line loads and steps with random stalls, checked against an in-bench line tracer.
// Depends on bls_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_bresenham_line_stepper_core;
    import bls_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int IN_W = ((4 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
    localparam int N_ITEMS = 1200;

    typedef struct {
        t_func                 func;
        logic signed [CW-1:0]  xs;
        logic signed [CW-1:0]  ys;
        logic signed [CW-1:0]  xe;
        logic signed [CW-1:0]  ye;
        bit                    hold;
    } t_line_cmd;

    typedef struct {
        bit                    valid;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        bit                    last;
    } t_point;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [0:0]        s_tuser;
    logic              o_m_axis_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic [0:0]        o_m_axis_tuser;
    logic              o_m_axis_tlast;

    bresenham_line_stepper_core #(.COORD_BITS(CW)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),     // x_start, y_start, x_end, y_end
        .i_s_axis_tuser  (s_tuser),     // func
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata), // point_x, point_y
        .o_m_axis_tuser  (o_m_axis_tuser), // point_valid
        .o_m_axis_tlast  (o_m_axis_tlast)  // last_point
    );

    // tracer state
    logic signed [CW-1:0]   pos_x;
    logic signed [CW-1:0]   pos_y;
    logic signed [CW+3:0]   err_acc;
    logic [CW-1:0]          abs_dx;
    logic [CW-1:0]          abs_dy;
    t_line_flags            dirs;
    logic [CW-1:0]          steps_togo;
    bit                     drawing;

    t_line_cmd  line_cmds[$];
    t_point     points_due[$];
    t_line_cmd  cur_cmd;
    bit         s_took;
    int         n_in;
    int         n_bad;
    int         n_load;
    int         n_live;
    int         n_idle_step;
    int         n_ends;

    wire quiet = (n_in >= 500) && (n_in < 700);

    function automatic t_point trace_line(t_line_cmd c);
        int     dx;
        int     dy;
        int     major;
        int     minor;
        t_point p;
        p = '{valid: 1'b0, x: '0, y: '0, last: 1'b0};
        if (c.func == FUNC_LOAD) begin
            dx = int'(c.xe) - int'(c.xs);
            dy = int'(c.ye) - int'(c.ys);
            dirs.x_dir_neg = dx < 0;
            dirs.y_dir_neg = dy < 0;
            abs_dx = CW'(dx < 0 ? -dx : dx);
            abs_dy = CW'(dy < 0 ? -dy : dy);
            dirs.steep = abs_dx < abs_dy;
            if (dirs.steep) begin
                err_acc = (CW+4)'(2 * int'(abs_dx) - int'(abs_dy));
                steps_togo = abs_dy;
            end else begin
                err_acc = (CW+4)'(2 * int'(abs_dy) - int'(abs_dx));
                steps_togo = abs_dx;
            end
            pos_x = c.xs;
            pos_y = c.ys;
            drawing = steps_togo != 0;
            p = '{valid: 1'b1, x: pos_x, y: pos_y, last: steps_togo == 0};
        end else if (drawing) begin
            major = dirs.steep ? int'(abs_dy) : int'(abs_dx);
            minor = dirs.steep ? int'(abs_dx) : int'(abs_dy);
            if (err_acc > 0) begin
                if (dirs.steep)
                    pos_x = dirs.x_dir_neg ? pos_x - 1'b1 : pos_x + 1'b1;
                else
                    pos_y = dirs.y_dir_neg ? pos_y - 1'b1 : pos_y + 1'b1;
                err_acc = (CW+4)'(int'(err_acc) - 2 * major);
            end
            if (dirs.steep)
                pos_y = dirs.y_dir_neg ? pos_y - 1'b1 : pos_y + 1'b1;
            else
                pos_x = dirs.x_dir_neg ? pos_x - 1'b1 : pos_x + 1'b1;
            err_acc = (CW+4)'(int'(err_acc) + 2 * minor);
            steps_togo = steps_togo - 1'b1;
            if (steps_togo == 0)
                drawing = 1'b0;
            p = '{valid: 1'b1, x: pos_x, y: pos_y, last: steps_togo == 0};
        end
        return p;
    endfunction

    function automatic int rnd_coord();
        return int'($urandom_range(2 ** CW - 1)) - 2 ** (CW - 1);
    endfunction

    function automatic int clamp_coord(int v);
        if (v > 2 ** (CW - 1) - 1)
            return 2 ** (CW - 1) - 1;
        if (v < -(2 ** (CW - 1)))
            return -(2 ** (CW - 1));
        return v;
    endfunction

    task automatic add_line(int xs, int ys, int xe, int ye, int nsteps, bit hold);
        t_line_cmd c;
        c = '{func: FUNC_LOAD, xs: CW'(xs), ys: CW'(ys), xe: CW'(xe), ye: CW'(ye),
              hold: hold};
        line_cmds.push_back(c);
        repeat (nsteps) begin
            // step items carry junk coordinates, which the core must ignore
            c = '{func: FUNC_STEP, xs: CW'(rnd_coord()), ys: CW'(rnd_coord()),
                  xe: CW'(rnd_coord()), ye: CW'(rnd_coord()), hold: 1'b0};
            line_cmds.push_back(c);
        end
    endtask

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_tvalid || s_took) begin
                if (line_cmds.size() != 0
                    && !(line_cmds[0].hold && points_due.size() != 0)
                    && (quiet || $urandom_range(99) >= 14)) begin
                    cur_cmd = line_cmds.pop_front();
                    s_tdata <= {cur_cmd.ye, cur_cmd.xe, cur_cmd.ys, cur_cmd.xs};
                    s_tuser <= cur_cmd.func;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    // monitor and tracer
    always @(posedge i_clk) begin : mon
        t_point               want;
        logic signed [CW-1:0] got_x;
        logic signed [CW-1:0] got_y;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_tready) begin
                got_x = o_m_axis_tdata[CW-1:0];
                got_y = o_m_axis_tdata[2*CW-1:CW];
                if (points_due.size() == 0) begin
                    $error("unexpected output transfer x=%0d y=%0d", got_x, got_y);
                    n_bad++;
                end else begin
                    want = points_due.pop_front();
                    if (o_m_axis_tuser[0] !== want.valid) begin
                        $error("point_valid expected %0d got %0d", want.valid,
                               o_m_axis_tuser[0]);
                        n_bad++;
                    end
                    if (got_x !== want.x) begin
                        $error("point_x expected %0d got %0d", want.x, got_x);
                        n_bad++;
                    end
                    if (got_y !== want.y) begin
                        $error("point_y expected %0d got %0d", want.y, got_y);
                        n_bad++;
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        $error("last_point expected %0d got %0d", want.last,
                               o_m_axis_tlast);
                        n_bad++;
                    end
                end
            end
            s_took = s_tvalid && o_s_axis_tready;
            if (s_took) begin
                want = trace_line(cur_cmd);
                points_due.push_back(want);
                n_in++;
                if (cur_cmd.func == FUNC_LOAD)
                    n_load++;
                else if (want.valid)
                    n_live++;
                else
                    n_idle_step++;
                if (want.last)
                    n_ends++;
            end
        end else begin
            s_took = 1'b0;
        end
    end

    initial begin
        #2_000_000;
        $display("bresenham_line_stepper_core regression: fail");
        $finish;
    end

    initial begin : stim
        int  xs;
        int  ys;
        int  xe;
        int  ye;
        int  span;
        int  major;
        int  nsteps;
        int  pick;
        int  live;
        int  lines;
        t_line_cmd c;

        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD;
        m_tready = 1'b0;
        s_took = 1'b0;
        n_in = 0;
        n_bad = 0;
        n_load = 0;
        n_live = 0;
        n_idle_step = 0;
        n_ends = 0;
        drawing = 1'b0;
        pos_x = '0;
        pos_y = '0;
        err_acc = '0;
        abs_dx = '0;
        abs_dy = '0;
        dirs = '0;
        steps_togo = '0;

        // directed: step out of reset, point line, extremes, replace, octants, diagonal
        c = '{func: FUNC_STEP, xs: '1, ys: '1, xe: '1, ye: '1, hold: 1'b0};
        line_cmds.push_back(c);
        add_line(5, -3, 5, -3, 1, 1'b0);
        add_line(-2048, -2048, 2047, 2047, 2, 1'b0);
        add_line(2047, -2048, -2048, 2047, 1, 1'b0);
        add_line(10, 10, 12, 11, 2, 1'b0);
        add_line(-7, 3, -8, 5, 2, 1'b0);
        add_line(0, 0, -2, -1, 2, 1'b0);
        add_line(100, -100, 101, -102, 2, 1'b0);
        add_line(-1, 1, 1, -1, 3, 1'b1);

        // random lines, mostly short and stepped to their end
        live = 0;
        lines = 0;
        while (live < N_ITEMS) begin
            pick = $urandom_range(99);
            xs = rnd_coord();
            ys = rnd_coord();
            if (pick < 85) begin
                span = ($urandom_range(99) < 3) ? 300 :
                       ($urandom_range(99) < 10) ? 63 : 15;
                xe = clamp_coord(xs + int'($urandom_range(2 * span)) - span);
                ye = clamp_coord(ys + int'($urandom_range(2 * span)) - span);
                major = (xe > xs ? xe - xs : xs - xe);
                if ((ye > ys ? ye - ys : ys - ye) > major)
                    major = (ye > ys ? ye - ys : ys - ye);
                nsteps = major;
                pick = $urandom_range(99);
                if (pick < 15 && major > 1)
                    nsteps = $urandom_range(major - 1);
                else if (pick < 25)
                    nsteps = major + $urandom_range(1, 2);
                add_line(xs, ys, xe, ye, nsteps, lines % 40 == 39);
                live += 1 + (nsteps < major ? nsteps : major);
            end else if (pick < 95) begin
                xe = rnd_coord();
                ye = rnd_coord();
                nsteps = $urandom_range(3);
                add_line(xs, ys, xe, ye, nsteps, 1'b0);
                live += 1 + nsteps;
            end else begin
                c = '{func: FUNC_STEP, xs: CW'(xs), ys: CW'(ys), xe: CW'(rnd_coord()),
                      ye: CW'(rnd_coord()), hold: 1'b0};
                line_cmds.push_back(c);
            end
            lines++;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (line_cmds.size() == 0 && !s_tvalid);
        wait (points_due.size() == 0);
        repeat (5) @(posedge i_clk);
        if (points_due.size() != 0) begin
            $error("%0d points still outstanding at end of run", points_due.size());
            n_bad++;
        end
        $display("Ran %0d transfers: %0d line loads, %0d live steps, %0d steps with no line,",
                 n_in, n_load, n_live, n_idle_step);
        $display("%0d line end points, all octants, stalls on both sides.", n_ends);
        if (n_bad == 0)
            $display("bresenham_line_stepper_core regression: pass");
        else
            $display("bresenham_line_stepper_core regression: fail");
        $finish;
    end

endmodule
